// ----- hw/rtl/sample_ring_edge_trigger_top_assert.svh -----
// Assertion macros for the sample ring edge trigger top level.
// Used by sample_ring_edge_trigger_top.sv; expects clk_i and rst_ni in scope.
`ifndef SAMPLE_RING_EDGE_TRIGGER_TOP_ASSERT_SVH
`define SAMPLE_RING_EDGE_TRIGGER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define SRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/srtrig_pkg.sv -----
// Package for the sample ring edge trigger: sizes, item types, control structs.
// No dependencies; imported by the top level and the search engine.
`default_nettype none

package srtrig_pkg;

  // Ring geometry (depth must be a power of two)
  localparam int RING_DEPTH  = 2048;
  localparam int HALF_SCREEN = 64;
  localparam int SAMPLE_BITS = 12;
  localparam int LEVEL_W     = 12;
  localparam int ERR_W       = 16;

  localparam int IDX_W     = $clog2(RING_DEPTH);
  localparam int FILL_W    = IDX_W + 1;
  localparam int SPAN      = RING_DEPTH / 2;
  localparam int CNT_W     = $clog2(SPAN);
  localparam int HALF_WRAP = HALF_SCREEN % RING_DEPTH;
  localparam int CMP_W     = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

  localparam logic [IDX_W-1:0]   NEWEST_RST = IDX_W'(RING_DEPTH - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_RST  = LEVEL_W'(2048);
  localparam logic [ERR_W-1:0]   ERR_MAX    = '1;

  // Item modes
  localparam logic MODE_STORE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   overflow_seen;
    logic                   falling_edge;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] trigger_index;
    logic [ERR_W-1:0] error_count;
  } out_item_t;

  // Ring bookkeeping seen by the search engine
  typedef struct packed {
    logic [IDX_W-1:0]   newest;
    logic [FILL_W-1:0]  fill;
    logic [LEVEL_W-1:0] level;
  } ring_status_t;

  // Search engine status back to the top level
  typedef struct packed {
    logic             busy;
    logic             valid;
    logic [IDX_W-1:0] index;
  } srch_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sample_ring_edge_trigger_top.sv -----
// Top level of the sample ring edge trigger: store path, ring RAM, output stage.
// Depends on srtrig_pkg, srtrig_ram, srtrig_search and the assertion header.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_item_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i out_item_o (out_item_t)
//   cfg       input      cfg_we_i                  cfg_wdata_i (trigger level)
//
// A store item makes one RAM write and gives no result.
// A search item walks back through the ring, one ring read per cycle
// through the single RAM read port, then hands over the result.
// Reset needs no clearing pass: a fill count marks never-written entries as zero.
// A stalled output holds its result; store items are still taken meanwhile
// unless a search is busy, and a finished search waits until the output register frees up.
`default_nettype none

`include "sample_ring_edge_trigger_top_assert.svh"

module sample_ring_edge_trigger_top
  import srtrig_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [LEVEL_W-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_item_o
);

  logic [IDX_W-1:0]   newest_q, newest_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [ERR_W-1:0]   err_q, err_d;
  logic [LEVEL_W-1:0] level_q;
  logic               out_valid_q;
  out_item_t          out_item_q;

  logic                   in_acc;
  logic                   store_acc;
  logic                   search_acc;
  logic [IDX_W-1:0]       raddr;
  logic [SAMPLE_BITS-1:0] rdata;
  ring_status_t           ring_st;
  srch_res_t              srch_res;
  logic                   res_take;

  assign in_stall_o = srch_res.busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store_acc  = in_acc && (in_item_i.mode == MODE_STORE);
  assign search_acc = in_acc && (in_item_i.mode == MODE_SEARCH);

  // Store path: advance newest, grow fill count, count overflows
  always_comb begin
    newest_d = newest_q;
    fill_d   = fill_q;
    err_d    = err_q;
    if (store_acc) begin
      newest_d = newest_q + IDX_W'(1);
      if (!fill_q[IDX_W]) begin
        fill_d = fill_q + FILL_W'(1);
      end
      if (in_item_i.overflow_seen && (err_q != ERR_MAX)) begin
        err_d = err_q + ERR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= NEWEST_RST;
      fill_q   <= '0;
      err_q    <= '0;
      level_q  <= LEVEL_RST;
    end else begin
      newest_q <= newest_d;
      fill_q   <= fill_d;
      err_q    <= err_d;
      if (cfg_we_i) begin
        level_q <= cfg_wdata_i;
      end
    end
  end

  // Sample ring storage
  srtrig_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (store_acc),
    .waddr_i (newest_d),
    .wdata_i (in_item_i.sample_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ring_st.newest = newest_q;
  assign ring_st.fill   = fill_q;
  assign ring_st.level  = level_q;

  // Edge search engine
  srtrig_search u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (search_acc),
    .falling_i  (in_item_i.falling_edge),
    .ring_i     (ring_st),
    .rdata_i    (rdata),
    .res_take_i (res_take),
    .raddr_o    (raddr),
    .res_o      (srch_res)
  );

  // Output register
  assign res_take = srch_res.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_item_q.trigger_index <= srch_res.index;
      out_item_q.error_count   <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  `SRT_ASSERT_NEXT(a_search_busy, search_acc, in_stall_o, "search item did not make the block busy")
  `SRT_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_W'(RING_DEPTH), "fill count beyond ring depth")
  `SRT_ASSERT_NEXT(a_store_adv, store_acc, newest_q == $past(newest_q) + IDX_W'(1), "newest index did not advance")
  `SRT_ASSERT_NEXT(a_res_out, res_take, out_valid_o && !in_stall_o, "taken result not presented")

endmodule

`default_nettype wire

// ----- hw/rtl/srtrig_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module srtrig_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/srtrig_search.sv -----
// Backward edge search engine: walks the ring one read per cycle.
// Depends on srtrig_pkg; drives the read port of the ring RAM.
`default_nettype none

module srtrig_search
  import srtrig_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic                   falling_i,
  input  wire ring_status_t           ring_i,
  input  wire logic [SAMPLE_BITS-1:0] rdata_i,
  input  wire logic                   res_take_i,
  output logic      [IDX_W-1:0]       raddr_o,
  output srch_res_t                   res_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   pos_q, pos_d;       // address whose data is on rdata_i
  logic [IDX_W-1:0]   start_q, start_d;
  logic [IDX_W-1:0]   index_q, index_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               first_q, first_d;
  logic               prev_hi_q, prev_hi_d; // level flag of entry pos_q + 1
  logic               falling_q, falling_d;

  logic [IDX_W-1:0]       start_w;
  logic                   ent_ok;
  logic [SAMPLE_BITS-1:0] samp;
  logic                   hi;
  logic                   match;

  assign start_w = ring_i.newest - IDX_W'(HALF_WRAP);

  // Entries at or past the fill count were never written and read as zero
  assign ent_ok = ring_i.fill[IDX_W] || ({1'b0, pos_q} < ring_i.fill);
  assign samp   = ent_ok ? rdata_i : '0;
  assign hi     = CMP_W'(samp) >= CMP_W'(ring_i.level);
  assign match  = falling_q ? (!prev_hi_q && hi) : (prev_hi_q && !hi);

  // Read address: start point on launch, then one step older each cycle
  assign raddr_o = (state_q == ST_IDLE) ? start_w : pos_q - IDX_W'(1);

  assign res_o.busy  = (state_q != ST_IDLE);
  assign res_o.valid = (state_q == ST_DONE);
  assign res_o.index = index_q;

  // Scan sequencer
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    start_d   = start_q;
    index_d   = index_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    prev_hi_d = prev_hi_q;
    falling_d = falling_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          pos_d     = start_w;
          start_d   = start_w;
          cnt_d     = '0;
          first_d   = 1'b1;
          falling_d = falling_i;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (first_q) begin
          prev_hi_d = hi;
          first_d   = 1'b0;
          pos_d     = pos_q - IDX_W'(1);
        end else if (match) begin
          index_d = pos_q + IDX_W'(1);
          state_d = ST_DONE;
        end else if (cnt_q == CNT_W'(SPAN - 1)) begin
          index_d = start_q;
          state_d = ST_DONE;
        end else begin
          cnt_d     = cnt_q + CNT_W'(1);
          prev_hi_d = hi;
          pos_d     = pos_q - IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Scan datapath
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    start_q   <= start_d;
    index_q   <= index_d;
    cnt_q     <= cnt_d;
    first_q   <= first_d;
    prev_hi_q <= prev_hi_d;
    falling_q <= falling_d;
  end

endmodule

`default_nettype wire
